@@ hw/rtl/bces_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic compare-exchange store package
// Shared sizes, action codes and the stored pair type.
// ----------------------------------------------------------------------------
package bces_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int POS_W     = 10;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int MASK_W    = 11;
    localparam int STRIDE_W  = 10;
    localparam int COUNT_W   = 11;
    localparam int ACTION_W  = 2;
    localparam int ENTRY_W   = KEY_W + PAY_W;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

@@ hw/rtl/bces_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-port synchronous RAM
// Two independent ports, each reading or writing one word per cycle, with
// registered read data that holds while the port is not enabled.
// ----------------------------------------------------------------------------
module bces_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              a_en,
    input  logic              a_we,
    input  logic [ADDR_W-1:0] a_addr,
    input  logic [WIDTH-1:0]  a_wdata,
    output logic [WIDTH-1:0]  a_rdata,
    input  logic              b_en,
    input  logic              b_we,
    input  logic [ADDR_W-1:0] b_addr,
    input  logic [WIDTH-1:0]  b_wdata,
    output logic [WIDTH-1:0]  b_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            if (a_we)
            begin
                mem[a_addr] <= a_wdata;
            end
            else
            begin
                a_rdata <= mem[a_addr];
            end
        end
        if (b_en)
        begin
            if (b_we)
            begin
                mem[b_addr] <= b_wdata;
            end
            else
            begin
                b_rdata <= mem[b_addr];
            end
        end
    end

endmodule

@@ hw/rtl/bces_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare-exchange decision
// Orders two pairs by key, with the payload breaking ties, and flags
// an exchange when they are out of order for the requested direction.
// ----------------------------------------------------------------------------
module bces_cmp (
    input  bces_pkg::entry_t lower,
    input  bces_pkg::entry_t upper,
    input  logic             ascending,
    output logic             swap
);
    import bces_pkg::*;

    logic lower_gt;
    logic upper_gt;

    always_comb
    begin
        if (lower.key != upper.key)
        begin
            lower_gt = lower.key > upper.key;
            upper_gt = upper.key > lower.key;
        end
        else
        begin
            lower_gt = lower.payload > upper.payload;
            upper_gt = upper.payload > lower.payload;
        end
        swap = ascending ? lower_gt : upper_gt;
    end

endmodule

@@ hw/rtl/bitonic_compare_exchange_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic compare-exchange store unit
// Holds key/payload pairs in a dual-port RAM and runs write, read and
// compare-exchange items against it.
//
// Items arrive on the s_ channel: the action in s_tuser, the position, key,
// payload, direction mask and stride in s_tdata. Every item yields one
// result transfer on the m_ channel: key and payload in m_tdata, the swapped
// and skipped flags in m_tuser.
// A write, a skipped step, an out-of-range read or an unused action has its
// result registered and shown the cycle after it is taken. A read fetches
// one entry and an active step both from the RAM; ST_EXEC then compares,
// writes back a swapped pair, registers the result and takes no new item.
// The element count is set through the APB port at byte address 0 and must
// only be changed while no item is in flight.
// Reset clears the element count and the output valid; the RAM contents are
// undefined until written. While the receiver stalls, the result is held
// and no new item is taken.
// ----------------------------------------------------------------------------
module bitonic_compare_exchange_store_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // position[9:0], key_in[41:10], payload_in[73:42], subsequence_mask[84:74],
    // stride[94:85], zero[95]
    input  logic [bces_pkg::S_DATA_W-1:0]      s_tdata,
    // action[1:0]
    input  logic [bces_pkg::ACTION_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // key_out[31:0], payload_out[63:32]
    output logic [bces_pkg::M_DATA_W-1:0]      m_tdata,
    // swapped[0], skipped[1]
    output logic [1:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bces_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bces_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bces_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import bces_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]  element_count_reg;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   partner_reg, partner_next;
    logic                asc_reg, asc_next;
    logic                is_step_reg, is_step_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;

    logic [POS_W-1:0]    in_pos;
    logic [KEY_W-1:0]    in_key;
    logic [PAY_W-1:0]    in_pay;
    logic [MASK_W-1:0]   in_mask;
    logic [STRIDE_W-1:0] in_stride;
    action_t             in_action;
    logic [POS_W-1:0]    in_partner;
    logic                pos_ok;
    logic                step_skip;
    logic                accept;
    logic                cfg_write;

    logic                a_en, a_we, b_en, b_we;
    logic [ADDR_W-1:0]   a_addr, b_addr;
    entry_t              a_wdata, b_wdata, a_rdata, b_rdata;
    logic                swap;

    assign in_pos     = s_tdata[9:0];
    assign in_key     = s_tdata[41:10];
    assign in_pay     = s_tdata[73:42];
    assign in_mask    = s_tdata[84:74];
    assign in_stride  = s_tdata[94:85];
    assign in_action  = action_t'(s_tuser);
    assign in_partner = in_pos ^ in_stride;

    assign pos_ok    = int'(in_pos) < DEPTH;
    assign step_skip = !pos_ok || (in_partner <= in_pos)
                       || ({1'b0, in_partner} >= element_count_reg)
                       || (int'(in_partner) >= DEPTH);

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? '0 : APB_DATA_W'(element_count_reg);

    bces_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .a_en    (a_en),
        .a_we    (a_we),
        .a_addr  (a_addr),
        .a_wdata (a_wdata),
        .a_rdata (a_rdata),
        .b_en    (b_en),
        .b_we    (b_we),
        .b_addr  (b_addr),
        .b_wdata (b_wdata),
        .b_rdata (b_rdata)
    );

    bces_cmp u_cmp (
        .lower     (a_rdata),
        .upper     (b_rdata),
        .ascending (asc_reg),
        .swap      (swap)
    );

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        partner_next  = partner_reg;
        asc_next      = asc_reg;
        is_step_next  = is_step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        a_en    = 1'b0;
        a_we    = 1'b0;
        a_addr  = ADDR_W'(in_pos);
        a_wdata = '{payload: in_pay, key: in_key};
        b_en    = 1'b0;
        b_we    = 1'b0;
        b_addr  = ADDR_W'(in_partner);
        b_wdata = a_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next     = ADDR_W'(in_pos);
                    partner_next = ADDR_W'(in_partner);
                    asc_next     = ({1'b0, in_pos} & in_mask) == '0;
                    is_step_next = in_action == ACT_STEP;
                    m_tdata_next = '0;
                    m_tuser_next = 2'b00;
                    case (in_action)
                        ACT_WRITE:
                        begin
                            a_en          = pos_ok;
                            a_we          = 1'b1;
                            m_tvalid_next = 1'b1;
                        end
                        ACT_READ:
                        begin
                            if (pos_ok)
                            begin
                                a_en       = 1'b1;
                                state_next = ST_EXEC;
                            end
                            else
                            begin
                                m_tvalid_next = 1'b1;
                            end
                        end
                        ACT_STEP:
                        begin
                            if (step_skip)
                            begin
                                m_tuser_next  = 2'b10;
                                m_tvalid_next = 1'b1;
                            end
                            else
                            begin
                                a_en       = 1'b1;
                                b_en       = 1'b1;
                                state_next = ST_EXEC;
                            end
                        end
                        default:
                        begin
                            m_tvalid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                a_addr        = pos_reg;
                b_addr        = partner_reg;
                a_wdata       = b_rdata;
                b_wdata       = a_rdata;
                m_tvalid_next = 1'b1;
                state_next    = ST_IDLE;
                if (is_step_reg)
                begin
                    a_en         = swap;
                    a_we         = swap;
                    b_en         = swap;
                    b_we         = swap;
                    m_tdata_next = '0;
                    m_tuser_next = {1'b0, swap};
                end
                else
                begin
                    m_tdata_next = {a_rdata.payload, a_rdata.key};
                    m_tuser_next = 2'b00;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        partner_reg <= partner_next;
        asc_reg     <= asc_next;
        is_step_reg <= is_step_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            element_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

endmodule
